// ===== rtl/rvf_pkg.sv =====
`timescale 1ns / 1ps
package rvf_pkg;

  localparam logic [2:0] MODE_RAW     = 3'd0;
  localparam logic [2:0] MODE_INT8    = 3'd1;
  localparam logic [2:0] MODE_INT16   = 3'd2;
  localparam logic [2:0] MODE_UNIFORM = 3'd3;
  localparam logic [2:0] MODE_DOWNEY  = 3'd4;

  localparam logic [1:0] CORE_BOTH = 2'd0;
  localparam logic [1:0] CORE_XOR  = 2'd1;
  localparam logic [1:0] CORE_A    = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_CORE  = 2'd1;
  localparam logic [1:0] REG_BOUND = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  localparam logic [6:0]  EXP_START  = 7'd126;
  localparam logic [4:0]  MANT_BITS  = 5'd23;
  localparam logic [7:0]  EXP_BIAS_LO = 8'd104;
  localparam logic [15:0] BYTE_MAX   = 16'h00FF;

  typedef struct packed {
    logic        two;
    logic [31:0] v0;
    logic        rl0;
    logic [31:0] v1;
    logic        rl1;
  } ent_t;

  typedef struct packed {
    logic        inm;
    logic [6:0]  ex;
    logic [22:0] man;
    logic [4:0]  tak;
  } dn_t;

  typedef struct packed {
    dn_t         s;
    logic        emit;
    logic [31:0] v;
  } dres_t;

  function automatic dres_t dn_byte(input dn_t s, input logic [7:0] bits,
                                    input logic stop_end);
    dres_t r;
    logic  stopped;
    r.s = s;
    r.emit = 1'b0;
    r.v = '0;
    stopped = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stopped) begin
        if (!r.s.inm) begin
          if (!bits[i] && r.s.ex != 7'd0) begin
            r.s.ex = r.s.ex - 7'd1;
          end else begin
            r.s.inm = 1'b1;
          end
        end else begin
          r.s.man = {r.s.man[21:0], bits[i]};
          r.s.tak = r.s.tak + 5'd1;
          if (r.s.tak >= MANT_BITS) begin
            r.emit = 1'b1;
            r.v = {1'b0, 1'b0, r.s.ex, r.s.man};
            r.s.inm = 1'b0;
            r.s.ex = EXP_START;
            r.s.man = '0;
            r.s.tak = '0;
            stopped = stop_end;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] cover_mask(input logic [15:0] b);
    logic [15:0] m;
    m = b;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

  function automatic logic [4:0] msb23(input logic [22:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/random_variate_formatter.sv =====
`timescale 1ns / 1ps
// Items pass the two-phase front end, queue and output register. The front end
// takes a new item only as the last leaves, reading Downey bits one byte per
// cycle if the queue is not full. Results leave up to one per cycle unless stalled.
// Reset (synchronous, active low) clears all gathering, counting and Downey state,
// empties the queue and sets mode 0, core 0, bound 255 and count 1.
module random_variate_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rand_a,
  input  logic [7:0]  in_rand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_item_last,
  output logic        out_request_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rvf_pkg::*;

  logic [2:0]  mode_r;
  logic [1:0]  core_r;
  logic [15:0] bound_r, count_r;
  logic        wr, q_full, push;
  ent_t        push_ent;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RAW;
      core_r <= CORE_BOTH;
      bound_r <= BYTE_MAX;
      count_r <= 16'd1;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODE:  mode_r <= pwdata[2:0];
        REG_CORE:  core_r <= pwdata[1:0];
        REG_BOUND: bound_r <= pwdata[15:0];
        REG_COUNT: count_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = {29'd0, mode_r};
      REG_CORE:  prdata = {30'd0, core_r};
      REG_BOUND: prdata = {16'd0, bound_r};
      REG_COUNT: prdata = {16'd0, count_r};
      default:   prdata = '0;
    endcase
  end

  rvf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_rand_a(in_rand_a), .in_rand_b(in_rand_b), .mode(mode_r),
    .core_sel(core_r), .bound(bound_r), .req_count(count_r),
    .q_full(q_full), .push(push), .push_ent(push_ent)
  );

  rvf_back u_back (
    .clk(clk), .rst_n(rst_n), .push(push), .push_ent(push_ent), .q_full(q_full),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_item_last(out_item_last), .out_request_last(out_request_last)
  );

endmodule

// ===== rtl/rvf_front.sv =====
`timescale 1ns / 1ps
module rvf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rand_a,
  input  logic [7:0]          in_rand_b,
  input  logic [2:0]          mode,
  input  logic [1:0]          core_sel,
  input  logic [15:0]         bound,
  input  logic [15:0]         req_count,
  input  logic                q_full,
  output logic                push,
  output rvf_pkg::ent_t       push_ent
);
  import rvf_pkg::*;

  logic        busy_r, busy_nxt, ph_r, ph_nxt;
  logic [7:0]  a_r, a_nxt, b_r, b_nxt;
  logic [1:0]  gather_r, gather_nxt;
  logic [23:0] wa_r, wa_nxt, wb_r, wb_nxt;
  logic [15:0] dlv_r, dlv_nxt;
  dn_t         dn_r, dn_nxt;
  logic        pend_r, pend_nxt, pend_rl_r, pend_rl_nxt;
  logic [31:0] pend_v_r, pend_v_nxt;
  logic        bp_r, bp_nxt, fl_r, fl_nxt;
  logic [15:0] bpa_r, bpa_nxt, bpb_r, bpb_nxt, bnd_r, bnd_nxt;
  logic [4:0]  pa_r, pa_nxt, pb_r, pb_nxt;

  logic        accept, fire;
  logic        c0, c1, end0, end1, c1e;
  logic [31:0] v0, v1;
  logic [15:0] d1, dmid, mask;
  dres_t       dr;
  logic [23:0] twa, twb;

  assign accept = in_valid && !in_stall;
  assign in_stall = busy_r && !(ph_r && !q_full);
  assign fire = busy_r && ph_r && !q_full;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt = ph_r;
    a_nxt = a_r;
    b_nxt = b_r;
    gather_nxt = gather_r;
    wa_nxt = wa_r;
    wb_nxt = wb_r;
    dlv_nxt = dlv_r;
    dn_nxt = dn_r;
    pend_nxt = pend_r;
    pend_rl_nxt = pend_rl_r;
    pend_v_nxt = pend_v_r;
    bp_nxt = bp_r;
    fl_nxt = fl_r;
    bpa_nxt = bpa_r;
    bpb_nxt = bpb_r;
    bnd_nxt = bnd_r;
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    push = 1'b0;
    push_ent = '0;
    c0 = 1'b0;
    c1 = 1'b0;
    v0 = '0;
    v1 = '0;
    end0 = 1'b0;
    end1 = 1'b0;
    c1e = 1'b0;
    d1 = dlv_r + 16'd1;
    dmid = dlv_r;
    mask = cover_mask(bnd_r);
    dr = '0;
    twa = wa_r;
    twb = wb_r;

    if (busy_r && !ph_r) begin
      ph_nxt = 1'b1;
      bp_nxt = 1'b0;
      fl_nxt = 1'b0;
      pend_nxt = 1'b0;
      pend_rl_nxt = 1'b0;
      bpa_nxt = {8'd0, a_r};
      bpb_nxt = {8'd0, b_r};
      bnd_nxt = bound;
      case (mode)
        MODE_INT8: begin
          bp_nxt = 1'b1;
          bnd_nxt = (bound > BYTE_MAX) ? BYTE_MAX : bound;
        end
        MODE_INT16: begin
          if (bound <= BYTE_MAX) begin
            gather_nxt = 2'd0;
            bp_nxt = 1'b1;
          end else if (gather_r == 2'd0) begin
            wa_nxt = {16'd0, a_r};
            wb_nxt = {16'd0, b_r};
            gather_nxt = 2'd1;
          end else begin
            wa_nxt = {8'd0, a_r, wa_r[7:0]};
            wb_nxt = {8'd0, b_r, wb_r[7:0]};
            gather_nxt = 2'd0;
            bp_nxt = 1'b1;
            bpa_nxt = {a_r, wa_r[7:0]};
            bpb_nxt = {b_r, wb_r[7:0]};
          end
        end
        MODE_UNIFORM: begin
          if (gather_r == 2'd0) begin
            wa_nxt = {16'd0, a_r};
            wb_nxt = {16'd0, b_r};
            gather_nxt = 2'd1;
          end else if (gather_r == 2'd1) begin
            wa_nxt = {8'd0, a_r, wa_r[7:0]};
            wb_nxt = {8'd0, b_r, wb_r[7:0]};
            gather_nxt = 2'd2;
          end else begin
            twa = {a_r, wa_r[15:0]};
            twb = {b_r, wb_r[15:0]};
            wa_nxt = twa;
            wb_nxt = twb;
            gather_nxt = 2'd0;
            fl_nxt = 1'b1;
            pa_nxt = msb23(twa[22:0]);
            pb_nxt = msb23(twb[22:0]);
          end
        end
        MODE_DOWNEY: begin
          dr = dn_byte(dn_r, a_r, d1 == req_count);
          dn_nxt = dr.s;
          if (dr.emit) begin
            pend_nxt = 1'b1;
            pend_v_nxt = dr.v;
            pend_rl_nxt = (d1 == req_count);
            dlv_nxt = (d1 == req_count) ? 16'd0 : d1;
          end
        end
        default: begin
        end
      endcase
    end

    if (fire) begin
      busy_nxt = 1'b0;
      ph_nxt = 1'b0;
      case (mode)
        MODE_RAW: begin
          end0 = (d1 == req_count);
          dlv_nxt = end0 ? 16'd0 : d1;
          push = 1'b1;
          if (core_sel == CORE_BOTH) begin
            push_ent = '{two: 1'b1, v0: {24'd0, a_r}, rl0: 1'b0,
                         v1: {24'd0, b_r}, rl1: end0};
          end else begin
            if (core_sel == CORE_XOR) begin
              v0 = {24'd0, a_r ^ b_r};
            end else if (core_sel == CORE_A) begin
              v0 = {24'd0, a_r};
            end else begin
              v0 = {24'd0, b_r};
            end
            push_ent = '{two: 1'b0, v0: v0, rl0: end0, v1: '0, rl1: 1'b0};
          end
        end
        MODE_DOWNEY: begin
          if (pend_r) begin
            push = 1'b1;
            push_ent = '{two: 1'b0, v0: pend_v_r, rl0: pend_rl_r, v1: '0, rl1: 1'b0};
            if (!pend_rl_r) begin
              dr = dn_byte(dn_r, b_r, d1 == req_count);
              dn_nxt = dr.s;
            end
          end else begin
            dr = dn_byte(dn_r, b_r, d1 == req_count);
            dn_nxt = dr.s;
            c0 = dr.emit;
            v0 = dr.v;
          end
        end
        default: begin
          if (bp_r) begin
            c0 = (bpa_r & mask) <= bnd_r;
            c1 = (bpb_r & mask) <= bnd_r;
            v0 = {16'd0, bpa_r & mask};
            v1 = {16'd0, bpb_r & mask};
          end else if (fl_r) begin
            c0 = 1'b1;
            c1 = 1'b1;
            v0 = (wa_r[22:0] == 23'd0) ? 32'd0 :
                 {1'b0, EXP_BIAS_LO + {3'd0, pa_r},
                  23'(wa_r[22:0] << (5'd23 - pa_r))};
            v1 = (wb_r[22:0] == 23'd0) ? 32'd0 :
                 {1'b0, EXP_BIAS_LO + {3'd0, pb_r},
                  23'(wb_r[22:0] << (5'd23 - pb_r))};
          end
        end
      endcase
      if (c0 || c1) begin
        end0 = c0 && (d1 == req_count);
        dmid = c0 ? (end0 ? 16'd0 : d1) : dlv_r;
        c1e = c1 && !end0;
        end1 = c1e && ((dmid + 16'd1) == req_count);
        dlv_nxt = c1e ? (end1 ? 16'd0 : dmid + 16'd1) : dmid;
        push = 1'b1;
        if (c0 && c1e) begin
          push_ent = '{two: 1'b1, v0: v0, rl0: end0, v1: v1, rl1: end1};
        end else if (c0) begin
          push_ent = '{two: 1'b0, v0: v0, rl0: end0, v1: '0, rl1: 1'b0};
        end else begin
          push_ent = '{two: 1'b0, v0: v1, rl0: end1, v1: '0, rl1: 1'b0};
        end
      end
    end

    if (accept) begin
      busy_nxt = 1'b1;
      ph_nxt = 1'b0;
      a_nxt = in_rand_a;
      b_nxt = in_rand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= 1'b0;
      gather_r <= '0;
      wa_r <= '0;
      wb_r <= '0;
      dlv_r <= '0;
      dn_r <= '{inm: 1'b0, ex: EXP_START, man: '0, tak: '0};
      pend_r <= 1'b0;
      bp_r <= 1'b0;
      fl_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r <= ph_nxt;
      gather_r <= gather_nxt;
      wa_r <= wa_nxt;
      wb_r <= wb_nxt;
      dlv_r <= dlv_nxt;
      dn_r <= dn_nxt;
      pend_r <= pend_nxt;
      bp_r <= bp_nxt;
      fl_r <= fl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    pend_rl_r <= pend_rl_nxt;
    pend_v_r <= pend_v_nxt;
    bpa_r <= bpa_nxt;
    bpb_r <= bpb_nxt;
    bnd_r <= bnd_nxt;
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
  end

endmodule

// ===== rtl/rvf_back.sv =====
`timescale 1ns / 1ps
module rvf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rvf_pkg::ent_t push_ent,
  output logic          q_full,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   out_value,
  output logic          out_item_last,
  output logic          out_request_last
);
  import rvf_pkg::*;

  ent_t        q_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt, idx_r, idx_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt, il_r, il_nxt, rl_r, rl_nxt;
  logic [31:0] val_r, val_nxt;
  logic        adv, pop;
  ent_t        head;

  assign q_full = (cnt_r == 2'd2);
  assign head = q_r[rp_r];
  assign adv = !ov_r || !out_stall;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    idx_nxt = idx_r;
    ov_nxt = ov_r;
    il_nxt = il_r;
    rl_nxt = rl_r;
    val_nxt = val_r;
    pop = 1'b0;
    if (adv) begin
      if (cnt_r != 2'd0) begin
        ov_nxt = 1'b1;
        val_nxt = idx_r ? head.v1 : head.v0;
        rl_nxt = idx_r ? head.rl1 : head.rl0;
        il_nxt = idx_r || !head.two;
        if (idx_r || !head.two) begin
          pop = 1'b1;
          idx_nxt = 1'b0;
          rp_nxt = !rp_r;
        end else begin
          idx_nxt = 1'b1;
        end
      end else begin
        ov_nxt = 1'b0;
      end
    end
    if (push) begin
      wp_nxt = !wp_r;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      idx_r <= 1'b0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_ent;
    end
    val_r <= val_nxt;
    il_r <= il_nxt;
    rl_r <= rl_nxt;
  end

  assign out_valid = ov_r;
  assign out_value = val_r;
  assign out_item_last = il_r;
  assign out_request_last = rl_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_idx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> idx_r == 1'b0)
    else $error("second result pending with empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("item pushed into full queue");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import rvf_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        item_last;
    logic        request_last;
  } variate_t;

  class variate_scoreboard;
    logic [2:0]  mode;
    logic [1:0]  core;
    logic [15:0] bound;
    logic [15:0] count;
    logic [1:0]  gather;
    logic [23:0] word_a;
    logic [23:0] word_b;
    logic [15:0] delivered;
    logic        in_mant;
    logic [6:0]  exponent;
    logic [22:0] mant;
    logic [4:0]  taken;
    variate_t    pending[$];
    variate_t    batch[$];
    int          mismatches;
    int          checked;

    function new();
      mode = MODE_RAW;
      core = CORE_BOTH;
      bound = 16'd255;
      count = 16'd1;
      gather = 0;
      word_a = 0;
      word_b = 0;
      delivered = 0;
      in_mant = 0;
      exponent = EXP_START;
      mant = 0;
      taken = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function bit bump_run();
      logic [15:0] nxt;
      nxt = delivered + 16'd1;
      bump_run = (nxt == count);
      delivered = bump_run ? 16'd0 : nxt;
    endfunction

    function bit push_value(logic [31:0] v);
      variate_t r;
      r.value = v;
      r.item_last = 0;
      r.request_last = bump_run();
      batch.push_back(r);
      return r.request_last;
    endfunction

    function logic [15:0] mask_for(logic [15:0] b);
      logic [16:0] m;
      m = 0;
      while (m < b) m = (m << 1) | 17'd1;
      return m[15:0];
    endfunction

    function logic [31:0] to_unit(logic [23:0] w);
      logic [22:0] m;
      int          p;
      m = w[22:0];
      if (m == 0) return 32'd0;
      p = 22;
      while (!m[p]) p--;
      return ((32'd104 + p) << 23) | ((32'(m) << (23 - p)) & 32'h007FFFFF);
    endfunction

    function void bounded(logic [15:0] va, logic [15:0] vb, logic [15:0] lim);
      logic [15:0] m;
      m = mask_for(lim);
      va &= m;
      vb &= m;
      if (va <= lim && push_value(32'(va))) return;
      if (vb <= lim) void'(push_value(32'(vb)));
    endfunction

    function void downey(logic [15:0] bits);
      for (int i = 0; i < 16; i++) begin
        if (!in_mant) begin
          if (!bits[i] && exponent != 0) exponent--;
          else in_mant = 1;
        end else begin
          mant = {mant[21:0], bits[i]};
          taken++;
          if (taken >= 23) begin
            logic [31:0] v;
            v = {2'b00, exponent, mant};
            in_mant = 0;
            exponent = EXP_START;
            mant = 0;
            taken = 0;
            if (push_value(v)) return;
          end
        end
      end
    endfunction

    function void note_pair(logic [7:0] a, logic [7:0] b);
      variate_t r;
      batch.delete();
      case (mode)
        MODE_RAW: begin
          if (core == CORE_BOTH) begin
            r.value = 32'(a); r.item_last = 0; r.request_last = 0;
            batch.push_back(r);
            r.value = 32'(b); r.request_last = bump_run();
            batch.push_back(r);
          end else begin
            r.value = (core == CORE_XOR) ? 32'(a ^ b) : (core == CORE_A) ? 32'(a) : 32'(b);
            r.item_last = 0;
            r.request_last = bump_run();
            batch.push_back(r);
          end
        end
        MODE_INT8: bounded(16'(a), 16'(b), (bound > 255) ? 16'd255 : bound);
        MODE_INT16: begin
          if (bound <= BYTE_MAX) begin
            gather = 0;
            bounded(16'(a), 16'(b), bound);
          end else if (gather == 0) begin
            word_a = 24'(a); word_b = 24'(b); gather = 1;
          end else begin
            word_a = {8'd0, a, word_a[7:0]};
            word_b = {8'd0, b, word_b[7:0]};
            gather = 0;
            bounded(word_a[15:0], word_b[15:0], bound);
          end
        end
        MODE_UNIFORM: begin
          if (gather == 0) begin
            word_a = 24'(a); word_b = 24'(b); gather = 1;
          end else if (gather == 1) begin
            word_a = {8'd0, a, word_a[7:0]};
            word_b = {8'd0, b, word_b[7:0]};
            gather = 2;
          end else begin
            word_a = {a, word_a[15:0]};
            word_b = {b, word_b[15:0]};
            gather = 0;
            if (!push_value(to_unit(word_a))) void'(push_value(to_unit(word_b)));
          end
        end
        MODE_DOWNEY: downey({b, a});
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].item_last = 1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    function void check_result(logic [31:0] v, logic il, logic rl);
      variate_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result value=%h", v);
        return;
      end
      e = pending.pop_front();
      if (e.value !== v || e.item_last !== il || e.request_last !== rl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result differs: expected %h/%b/%b, got %h/%b/%b",
                   e.value, e.item_last, e.request_last, v, il, rl);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rand_a;
  logic [7:0]  in_rand_b;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_value;
  logic        out_item_last;
  logic        out_request_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  variate_scoreboard board;
  int send_idle;
  int recv_idle;
  int items_sent;

  random_variate_formatter DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_value, out_item_last, out_request_last);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MODE:  board.mode = val[2:0];
      REG_CORE:  board.core = val[1:0];
      REG_BOUND: board.bound = val;
      default:   board.count = val;
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic send_pair(logic [7:0] a, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_rand_a <= a;
    in_rand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_pair(a, b);
    items_sent++;
  endtask

  task automatic set_all(logic [2:0] m, logic [1:0] c, logic [15:0] bd, logic [15:0] cnt);
    @(negedge clk);
    in_valid <= 0;
    drain();
    write_reg(REG_MODE, 16'(m));
    write_reg(REG_CORE, 16'(c));
    write_reg(REG_BOUND, bd);
    write_reg(REG_COUNT, cnt);
  endtask

  task automatic random_phase(int n);
    logic [2:0]  m;
    logic [15:0] bd;
    logic [15:0] cnt;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        m = 3'($urandom_range(5));
        case ($urandom_range(4))
          0: bd = 16'($urandom_range(255));
          1: bd = 16'hFFFF;
          2: bd = 16'd0;
          default: bd = 16'($urandom_range(65535));
        endcase
        cnt = ($urandom_range(5) == 0) ? 16'($urandom_range(65535))
                                       : 16'($urandom_range(1, 9));
        set_all(m, 2'($urandom_range(3)), bd, cnt);
      end
      send_pair(8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    board = new();
    rst_n = 0; in_valid = 0; in_rand_a = 0; in_rand_b = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 0; recv_idle = 0; items_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_pair(8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00);
    for (int c = 1; c < 4; c++) begin
      set_all(MODE_RAW, 2'(c), 16'd255, 16'd3);
      send_pair(8'hA5, 8'h5A);
      send_pair(8'hFF, 8'hFF);
    end
    set_all(MODE_INT8, CORE_BOTH, 16'hFFFF, 16'd2);
    send_pair(8'hFF, 8'h80);
    set_all(MODE_INT8, CORE_BOTH, 16'd0, 16'd0);
    send_pair(8'h12, 8'h34);
    set_all(MODE_INT16, CORE_BOTH, 16'd100, 16'd4);
    send_pair(8'd99, 8'd200);
    set_all(MODE_INT16, CORE_BOTH, 16'd1000, 16'd4);
    send_pair(8'hE7, 8'h03);
    send_pair(8'h03, 8'h04);
    set_all(MODE_UNIFORM, CORE_BOTH, 16'd255, 16'd1);
    send_pair(8'h00, 8'h01);
    send_pair(8'h00, 8'h00);
    send_pair(8'h00, 8'h7F);
    set_all(MODE_DOWNEY, CORE_BOTH, 16'd255, 16'd5);
    for (int i = 0; i < 10; i++) send_pair(8'h00, 8'h00);
    send_pair(8'hFF, 8'hFF);
    set_all(3'd7, CORE_BOTH, 16'd255, 16'd5);
    send_pair(8'h11, 8'h22);

    send_idle = 15; recv_idle = 85;
    random_phase(580);
    @(negedge clk);
    in_valid <= 0;
    drain();
    send_idle = 85; recv_idle = 15;
    random_phase(580);
    send_idle = 0; recv_idle = 0;
    random_phase(580);
    @(negedge clk);
    in_valid <= 0;
    drain();
    $display("Covered %0d items and %0d results over all modes, cores, bounds and counts.",
             items_sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== random_variate_formatter.f =====
rtl/rvf_pkg.sv
rtl/rvf_front.sv
rtl/rvf_back.sv
rtl/random_variate_formatter.sv
verif/testbench.sv
